### design/wps_pkg.sv
// wps_pkg: types, constants and helper functions for the weierstrass p series block
// holds the request and result structs, the sequencer states and the coefficient rom
// no dependencies
package wps_pkg;

	localparam int MAX_TERMS  = 50;
	localparam int BASE_TERMS = 20;
	localparam int IDX_W      = $clog2(MAX_TERMS);
	localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

	localparam logic signed [63:0] COEF2_Q60 = 64'sd681206265535954924;
	localparam logic [63:0] INT64_MAX_C = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN_C = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] z_real;
		logic signed [31:0] z_imag;
	} wps_arg_t;

	typedef struct packed {
		logic signed [63:0] p_real;
		logic signed [63:0] p_imag;
		logic               saturated;
		logic               at_pole;
	} wps_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SETUP,
		ST_STEP,
		ST_ROUND,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_DIV_NEXT,
		ST_OUT
	} wps_state_t;

	typedef logic signed [63:0] coef_arr_t [MAX_TERMS];

	function automatic logic [63:0] mag64(logic signed [63:0] x);
		logic [63:0] r;
		r = x[63] ? (~x) + 64'd1 : x;
		return r;
	endfunction

	// {clipped, value}
	function automatic logic [64:0] sat_mag(logic neg, logic [63:0] mag);
		logic [64:0] r;
		if (neg) begin
			if (mag > INT64_MIN_C) r = {1'b1, INT64_MIN_C};
			else r = {1'b0, (~mag) + 64'd1};
		end else begin
			if (mag[63]) r = {1'b1, INT64_MAX_C};
			else r = {1'b0, mag};
		end
		return r;
	endfunction

	// {clipped, value}
	function automatic logic [64:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
		logic [64:0] s;
		logic [64:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) r = {1'b1, (s[64] ? INT64_MIN_C : INT64_MAX_C)};
		else r = {1'b0, s[63:0]};
		return r;
	endfunction

	function automatic logic signed [63:0] mulsh60(logic signed [63:0] a, logic signed [63:0] b);
		logic [127:0] p;
		logic [63:0]  q;
		logic [64:0]  sv;
		p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
		p = p + (128'd1 << 59);
		q = (|p[127:124]) ? '1 : p[123:60];
		sv = sat_mag(a[63] ^ b[63], q);
		return sv[63:0];
	endfunction

	function automatic coef_arr_t coef_table();
		coef_arr_t c;
		logic signed [63:0] s;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		logic [64:0] sv;
		for (int k = 0; k < MAX_TERMS; k++) c[k] = '0;
		c[2] = COEF2_Q60;
		for (int k = 4; k < MAX_TERMS; k++) begin
			s = '0;
			for (int m = 2; m <= k - 2; m++) s = s + mulsh60(c[m], c[k - m]);
			den = 64'((2 * k + 1) * (k - 3));
			num = mag64(s) * 64'd3 + (den >> 1);
			rem = '0;
			quo = '0;
			for (int i = 63; i >= 0; i--) begin
				rem = {rem[62:0], num[i]};
				if (rem >= den) begin
					rem = rem - den;
					quo[i] = 1'b1;
				end
			end
			sv = sat_mag(s[63], quo);
			c[k] = sv[63:0];
		end
		return c;
	endfunction

	localparam coef_arr_t COEF = coef_table();

endpackage

### design/weierstrass_p_series.sv
// weierstrass_p_series: p function of the square period-2 lattice by laurent series
// one shared multiplier for squares and horner steps, one bit-serial divider for 1/z^2
// depends on wps_pkg
//
//  channel | valid     | stall     | payload             | direction
//  arg     | arg_valid | arg_stall | wps_arg_t (z)       | in
//  res     | res_valid | res_stall | wps_res_t (p, flags)| out
//
// per request: top = terms-1 in 19..49 horner steps;
//   each horner step is four products on the 34x32 multiplier,
//   the four divisions take one quotient bit a cycle (a clipped quotient skips the bit loop)
// a folded zero argument skips the series and goes straight to the output state
// reset clears the sequencer and the result valid; the coefficient rom is constant
// a new request is taken while a finished result still waits under res_stall
module weierstrass_p_series (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                arg_valid,
	output logic                arg_stall,
	input  wps_pkg::wps_arg_t   arg,
	output logic                res_valid,
	input  logic                res_stall,
	output wps_pkg::wps_res_t   res
);

	localparam logic signed [63:0] INT64_MAX_S = wps_pkg::INT64_MAX_C;

	wps_pkg::wps_state_t state_q, state_d;

	logic signed [17:0] zr_q, zi_q;
	logic signed [17:0] fzr, fzi;
	logic [1:0]  sq_cnt_q;
	logic [32:0] sqr_q, sqi_q, crs_q;
	logic signed [34:0] wr_q, wi_q;
	logic [33:0] m_q;

	logic [wps_pkg::IDX_W-1:0] k_q, k_m1, top_idx;
	logic [1:0]  prod_q, ph_q;
	logic signed [63:0] hr_q, hi_q, accr_q, acci_q;
	logic [65:0] pp_q;
	logic [97:0] full_q;
	logic signed [63:0] sr_q, si_q;

	logic [1:0]  div_sel_q;
	logic [33:0] r_q;
	logic [63:0] lo_q, quo_q, t_q;
	logic [5:0]  bit_q;

	logic signed [63:0] pr_q, pi_q;
	logic satr_q, sati_q, pole_q;

	logic     res_valid_q;
	wps_pkg::wps_res_t res_q;

	logic [33:0] mul_a;
	logic [31:0] mul_b;
	logic [65:0] mul_p;

	logic accept, load, pole_in;
	logic [16:0] magzr, magzi;
	logic [17:0] nzr, nzi;

	logic [33:0] m_d;
	logic signed [34:0] wr_d, wi_d, wi_pos;
	logic [39:0] tmul;
	logic [7:0]  nn, top;

	logic signed [34:0] op_a, neg_a;
	logic [33:0] amag;
	logic signed [63:0] op_b;
	logic [63:0] bmag;
	logic [65:0] q66;
	logic [63:0] qsat;
	logic [64:0] vsv;
	logic signed [63:0] v;

	logic signed [34:0] dnum, neg_dnum;
	logic [33:0] dmag;
	logic [33:0] div_hi;
	logic [63:0] div_lo;
	logic [34:0] r2, r2_sub;
	logic [64:0] dsv;

	logic [64:0] addr_sv, addi_sv;

	// adding or subtracting one full period is the same 18-bit operation
	function automatic logic signed [17:0] fold(logic signed [31:0] x);
		logic signed [17:0] r;
		r = {x[31] & (|x[16:0]), x[16:0]};
		if (r < -18'sd65536) r = r + 18'sh20000;
		else if (r > 18'sd65536) r = r - 18'sh20000;
		return r;
	endfunction

	function automatic logic signed [63:0] rnd28(logic signed [63:0] x);
		logic [64:0] s;
		logic [63:0] q;
		s = {1'b0, wps_pkg::mag64(x)} + 65'(28'h800_0000);
		q = {27'd0, s[64:28]};
		return x[63] ? (~q) + 64'd1 : q;
	endfunction

	assign accept    = arg_valid && !arg_stall;
	assign arg_stall = (state_q != wps_pkg::ST_IDLE);
	assign load      = (state_q == wps_pkg::ST_OUT) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign fzr     = fold(arg.z_real);
	assign fzi     = fold(arg.z_imag);
	assign pole_in = (fzr == '0) && (fzi == '0);

	assign nzr   = -zr_q;
	assign nzi   = -zi_q;
	assign magzr = zr_q[17] ? nzr[16:0] : zr_q[16:0];
	assign magzi = zi_q[17] ? nzi[16:0] : zi_q[16:0];

	// squares and terms count
	always_comb begin
		m_d    = {1'b0, sqr_q} + {1'b0, sqi_q};
		wr_d   = $signed({2'b00, sqr_q}) - $signed({2'b00, sqi_q});
		wi_pos = $signed({1'b0, crs_q, 1'b0});
		wi_d   = (zr_q[17] ^ zi_q[17]) ? -wi_pos : wi_pos;
		tmul   = 40'(m_d) * 40'(wps_pkg::MAX_TERMS);
		nn     = 8'(wps_pkg::BASE_TERMS) + {1'b0, tmul[39:33]};
		if (nn > 8'(wps_pkg::MAX_TERMS)) nn = 8'(wps_pkg::MAX_TERMS);
		top = nn - 8'd1;
		if (top < 8'd3) top = 8'd3;
		top_idx = top[wps_pkg::IDX_W-1:0];
	end

	// horner product operands
	always_comb begin
		op_a  = prod_q[0] ? wi_q : wr_q;
		neg_a = -op_a;
		amag  = op_a[34] ? neg_a[33:0] : op_a[33:0];
		op_b  = (prod_q[0] ^ prod_q[1]) ? hi_q : hr_q;
		bmag  = wps_pkg::mag64(op_b);
		q66   = full_q[97:32];
		qsat  = (|q66[65:64]) ? '1 : q66[63:0];
		vsv   = wps_pkg::sat_mag(op_a[34] ^ op_b[63], qsat);
		v     = vsv[63:0];
		k_m1  = k_q - wps_pkg::IDX_ONE;
	end

	// shared multiplier
	always_comb begin
		mul_a = amag;
		mul_b = (ph_q == 2'd0) ? bmag[31:0] : bmag[63:32];
		if (state_q == wps_pkg::ST_SQ) begin
			mul_a = {17'd0, (sq_cnt_q == 2'd1) ? magzi : magzr};
			mul_b = {15'd0, (sq_cnt_q == 2'd0) ? magzr : magzi};
		end
		mul_p = 66'(mul_a) * 66'(mul_b);
	end

	// divider operands and output sums
	always_comb begin
		dnum     = div_sel_q[1] ? wi_q : wr_q;
		neg_dnum = -dnum;
		dmag     = dnum[34] ? neg_dnum[33:0] : dnum[33:0];
		if (!div_sel_q[0]) begin
			div_hi = {1'b0, dmag[33:1]};
			div_lo = {dmag[0], 63'd0};
		end else begin
			div_hi = {33'd0, t_q[63]};
			div_lo = {t_q[62:0], 1'b0};
		end
		r2     = {r_q, lo_q[63]};
		r2_sub = r2 - {1'b0, m_q};
		dsv    = wps_pkg::sat_mag(dnum[34] ^ div_sel_q[1], quo_q);
		addr_sv = wps_pkg::add_sat(pr_q, sr_q);
		addi_sv = wps_pkg::add_sat(pi_q, si_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wps_pkg::ST_IDLE:
				if (accept) state_d = pole_in ? wps_pkg::ST_OUT : wps_pkg::ST_SQ;
			wps_pkg::ST_SQ:
				if (sq_cnt_q == 2'd2) state_d = wps_pkg::ST_SETUP;
			wps_pkg::ST_SETUP:
				state_d = wps_pkg::ST_STEP;
			wps_pkg::ST_STEP:
				if (ph_q == 2'd2 && prod_q == 2'd3 && k_q == wps_pkg::IDX_ONE)
					state_d = wps_pkg::ST_ROUND;
			wps_pkg::ST_ROUND:
				state_d = wps_pkg::ST_DIV_INIT;
			wps_pkg::ST_DIV_INIT:
				state_d = (div_hi >= m_q) ? wps_pkg::ST_DIV_NEXT : wps_pkg::ST_DIV_RUN;
			wps_pkg::ST_DIV_RUN:
				if (bit_q == '0) state_d = wps_pkg::ST_DIV_NEXT;
			wps_pkg::ST_DIV_NEXT:
				state_d = (div_sel_q == 2'd3) ? wps_pkg::ST_OUT : wps_pkg::ST_DIV_INIT;
			wps_pkg::ST_OUT:
				if (load) state_d = wps_pkg::ST_IDLE;
			default:
				state_d = wps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wps_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wps_pkg::ST_IDLE: begin
				if (accept) begin
					zr_q     <= fzr;
					zi_q     <= fzi;
					sq_cnt_q <= '0;
					pole_q   <= pole_in;
					satr_q   <= pole_in;
					sati_q   <= pole_in;
					pr_q     <= INT64_MAX_S;
					pi_q     <= '0;
				end
			end
			wps_pkg::ST_SQ: begin
				unique case (sq_cnt_q)
					2'd0:    sqr_q <= mul_p[32:0];
					2'd1:    sqi_q <= mul_p[32:0];
					default: crs_q <= mul_p[32:0];
				endcase
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end
			wps_pkg::ST_SETUP: begin
				wr_q   <= wr_d;
				wi_q   <= wi_d;
				m_q    <= m_d;
				k_q    <= top_idx;
				accr_q <= wps_pkg::COEF[top_idx];
				acci_q <= '0;
				hr_q   <= '0;
				hi_q   <= '0;
				prod_q <= '0;
				ph_q   <= '0;
			end
			wps_pkg::ST_STEP: begin
				unique case (ph_q)
					2'd0: begin
						pp_q <= mul_p;
						ph_q <= 2'd1;
					end
					2'd1: begin
						full_q <= {mul_p, 32'd0} + {32'd0, pp_q} + 98'(32'h8000_0000);
						ph_q   <= 2'd2;
					end
					default: begin
						ph_q <= 2'd0;
						unique case (prod_q)
							2'd0:    accr_q <= accr_q + v;
							2'd1:    accr_q <= accr_q - v;
							2'd2:    acci_q <= acci_q + v;
							default: begin
								hr_q   <= accr_q;
								hi_q   <= acci_q + v;
								k_q    <= k_m1;
								accr_q <= wps_pkg::COEF[k_m1];
								acci_q <= '0;
							end
						endcase
						prod_q <= prod_q + 2'd1;
					end
				endcase
			end
			wps_pkg::ST_ROUND: begin
				sr_q      <= rnd28(hr_q);
				si_q      <= rnd28(hi_q);
				div_sel_q <= '0;
			end
			wps_pkg::ST_DIV_INIT: begin
				r_q   <= div_hi;
				lo_q  <= div_lo;
				bit_q <= '1;
				quo_q <= (div_hi >= m_q) ? '1 : '0;
			end
			wps_pkg::ST_DIV_RUN: begin
				if (!r2_sub[34]) begin
					r_q   <= r2_sub[33:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					r_q   <= r2[33:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				lo_q  <= {lo_q[62:0], 1'b0};
				bit_q <= bit_q - 6'd1;
			end
			wps_pkg::ST_DIV_NEXT: begin
				if (!div_sel_q[0]) begin
					t_q <= quo_q;
				end else if (div_sel_q[1]) begin
					pi_q   <= dsv[63:0];
					sati_q <= dsv[64];
				end else begin
					pr_q   <= dsv[63:0];
					satr_q <= dsv[64];
				end
				div_sel_q <= div_sel_q + 2'd1;
			end
			wps_pkg::ST_OUT: begin
				if (load) begin
					res_q.p_real    <= satr_q ? pr_q : addr_sv[63:0];
					res_q.p_imag    <= sati_q ? pi_q : addi_sv[63:0];
					res_q.saturated <= satr_q | sati_q | (!satr_q & addr_sv[64])
						| (!sati_q & addi_sv[64]);
					res_q.at_pole   <= pole_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### dv/wps_checker.sv
// wps_checker: predicts and checks p(z) results of weierstrass_p_series
// watches the arg and res channels, keeps its own coefficient table and expected queue
// depends on wps_pkg for the request and result structs
module wps_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              arg_valid,
	input  logic              arg_stall,
	input  wps_pkg::wps_arg_t arg,
	input  logic              res_valid,
	input  logic              res_stall,
	input  wps_pkg::wps_res_t res,
	output int                fails,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

	longint   series_coef [wps_pkg::MAX_TERMS];
	wps_pkg::wps_res_t expected_p [$];

	function automatic logic [63:0] magnitude(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint apply_sign(bit neg, logic [63:0] mag, ref bit clipped);
		if (neg) begin
			if (mag > 64'h8000_0000_0000_0000) begin
				clipped = 1;
				return I64_MIN;
			end
			return -longint'(mag);
		end
		if (mag[63]) begin
			clipped = 1;
			return I64_MAX;
		end
		return longint'(mag);
	endfunction

	// rounded (a*b) >> sh, ties away from zero
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] p;
		logic [63:0] q;
		bit c;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		p = p + (128'd1 << (sh - 1));
		p = p >> sh;
		q = (p[127:64] != 0) ? '1 : p[63:0];
		c = 0;
		return apply_sign((a < 0) != (b < 0), q, c);
	endfunction

	function automatic logic [63:0] div_clip(logic [127:0] num, logic [63:0] d);
		logic [127:0] q;
		if (num[127:64] >= d) return '1;
		q = num / {64'd0, d};
		return q[63:0];
	endfunction

	function automatic longint recip_part(longint num, bit negate, logic [63:0] m,
		ref bit clipped);
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] q;
		a = magnitude(num);
		t = div_clip({1'b0, a, 63'd0}, m);
		q = div_clip({63'd0, t, 1'b0}, m);
		return apply_sign((num < 0) != negate, q, clipped);
	endfunction

	function automatic longint fold_coord(logic signed [31:0] raw);
		longint x;
		x = longint'(raw) % 131072;
		if (x < -65536) x += 131072;
		if (x > 65536) x -= 131072;
		return x;
	endfunction

	function automatic longint add_clip(longint a, longint b, ref bit clipped);
		if (b > 0 && a > I64_MAX - b) begin
			clipped = 1;
			return I64_MAX;
		end
		if (b < 0 && a < I64_MIN - b) begin
			clipped = 1;
			return I64_MIN;
		end
		return a + b;
	endfunction

	function automatic wps_pkg::wps_res_t predict_p(wps_pkg::wps_arg_t z);
		wps_pkg::wps_res_t r;
		longint zr, zi, wr, wi, hr, hi, nr, ni, sr, si, pr, pi;
		logic [63:0] m, nn;
		int top;
		bit satr, sati;
		satr = 0;
		sati = 0;
		zr = fold_coord(z.z_real);
		zi = fold_coord(z.z_imag);
		if (zr == 0 && zi == 0) begin
			r.p_real = I64_MAX;
			r.p_imag = 0;
			r.saturated = 1;
			r.at_pole = 1;
			return r;
		end
		wr = zr * zr - zi * zi;
		wi = 2 * zr * zi;
		m = 64'(zr * zr) + 64'(zi * zi);
		nn = wps_pkg::BASE_TERMS + ((m * wps_pkg::MAX_TERMS) >> 33);
		if (nn > wps_pkg::MAX_TERMS) nn = wps_pkg::MAX_TERMS;
		top = int'(nn) - 1;
		if (top < 3) top = 3;
		hr = 0;
		hi = 0;
		for (int k = top; k >= 2; k--) begin
			nr = series_coef[k] + mul_round(wr, hr, 32) - mul_round(wi, hi, 32);
			ni = mul_round(wr, hi, 32) + mul_round(wi, hr, 32);
			hr = nr;
			hi = ni;
		end
		sr = mul_round(wr, hr, 32) - mul_round(wi, hi, 32);
		si = mul_round(wr, hi, 32) + mul_round(wi, hr, 32);
		hr = mul_round(sr, 1, 28);
		hi = mul_round(si, 1, 28);
		pr = recip_part(wr, 0, m, satr);
		pi = recip_part(wi, 1, m, sati);
		if (!satr) pr = add_clip(pr, hr, satr);
		if (!sati) pi = add_clip(pi, hi, sati);
		r.p_real = pr;
		r.p_imag = pi;
		r.saturated = satr | sati;
		r.at_pole = 0;
		return r;
	endfunction

	initial begin
		longint s;
		logic [63:0] den, q;
		bit c;
		for (int k = 0; k < wps_pkg::MAX_TERMS; k++) series_coef[k] = 0;
		series_coef[2] = 64'sd681206265535954924;
		for (int k = 4; k < wps_pkg::MAX_TERMS; k++) begin
			s = 0;
			for (int j = 2; j <= k - 2; j++)
				s += mul_round(series_coef[j], series_coef[k - j], 60);
			den = 64'((2 * k + 1) * (k - 3));
			q = (magnitude(s) * 64'd3 + den / 2) / den;
			c = 0;
			series_coef[k] = apply_sign(s < 0, q, c);
		end
	end

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		wps_pkg::wps_res_t e;
		if (arst_n) begin
			if (arg_valid && !arg_stall) expected_p.push_back(predict_p(arg));
			if (res_valid && !res_stall) begin
				if (expected_p.size() == 0) begin
					$display("%t: unexpected result %h", $time, res);
					fails++;
				end else begin
					e = expected_p.pop_front();
					if (res.p_real !== e.p_real) begin
						$display("%t: p_real expected %h actual %h", $time, e.p_real, res.p_real);
						fails++;
					end
					if (res.p_imag !== e.p_imag) begin
						$display("%t: p_imag expected %h actual %h", $time, e.p_imag, res.p_imag);
						fails++;
					end
					if (res.saturated !== e.saturated) begin
						$display("%t: saturated expected %b actual %b", $time, e.saturated,
							res.saturated);
						fails++;
					end
					if (res.at_pole !== e.at_pole) begin
						$display("%t: at_pole expected %b actual %b", $time, e.at_pole,
							res.at_pole);
						fails++;
					end
				end
			end
			pending = expected_p.size();
		end
	end
endmodule

### dv/weierstrass_p_series_test.sv
// weierstrass_p_series_test: drives complex points into weierstrass_p_series
// directed corner points then random ones, with bursty requests and a stalling receiver
// depends on wps_pkg, weierstrass_p_series and wps_checker
module weierstrass_p_series_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              arg_valid;
	logic              arg_stall;
	wps_pkg::wps_arg_t arg;
	logic              res_valid;
	logic              res_stall;
	wps_pkg::wps_res_t res;
	int                fails;
	int                pending;
	int                stall_mode;

	weierstrass_p_series uut (.*);
	wps_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// receiver stall pattern, mode changes at random
	initial begin
		res_stall = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(299) == 0) stall_mode <= $urandom_range(2);
			case (stall_mode)
				0: res_stall <= 0;
				1: res_stall <= ($urandom_range(3) == 0);
				default: res_stall <= ($urandom_range(9) != 0);
			endcase
		end
	end

	task automatic send_point(logic [31:0] re, logic [31:0] im);
		arg_valid <= 1;
		arg <= {re, im};
		do @(posedge clk); while (arg_stall);
		if ($urandom_range(3) == 0) begin
			arg_valid <= 0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(131072)) - 65536);
			2: return 32'($signed($urandom_range(64)) - 32);
			default: return 32'($signed($urandom_range(4)) * 32'sh20000
				+ $signed($urandom_range(8)) - 4);
		endcase
	endfunction

	initial begin
		arst_n = 0;
		arg_valid = 0;
		arg = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_point(32'h0, 32'h0);
		send_point(32'h20000, 32'hFFFE0000);
		send_point(32'h10000, 32'h0);
		send_point(32'h0, 32'h10000);
		send_point(32'h10000, 32'h10000);
		send_point(32'hFFFF0000, 32'hFFFF0000);
		send_point(32'h1, 32'h0);
		send_point(32'h0, 32'hFFFFFFFF);
		send_point(32'h1, 32'h1);
		send_point(32'h80000000, 32'h7FFFFFFF);
		send_point(32'h7FFFFFFF, 32'h80000000);
		send_point(32'h80000000, 32'h80000000);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_point(32'h10001, 32'hFFFEFFFF);
		send_point(32'h100, 32'h0);
		send_point(32'h8000, 32'h8000);
		send_point(32'hB505, 32'h0);
		send_point(32'h0, 32'hFFFF8000);
		send_point(32'h3, 32'hFFFFFFFE);
		send_point(32'h12345678, 32'hEDCBA987);
		repeat (950) send_point(rand_coord(), rand_coord());
		arg_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fails == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

### filelist.f
design/wps_pkg.sv
design/weierstrass_p_series.sv
dv/wps_checker.sv
dv/weierstrass_p_series_test.sv
